### design/scrq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scrq_pkg: shared types and constants
// Operation codes, result codes and the command/status bundles that join
// the resend queue controller and its datapath.
// ----------------------------------------------------------------------------
package scrq_pkg;

  localparam logic [1:0]  OP_LOAD = 2'd0;
  localparam logic [1:0]  OP_TICK = 2'd1;
  localparam logic [1:0]  OP_ACK  = 2'd2;

  localparam logic        EV_TX   = 1'b0;
  localparam logic        EV_DROP = 1'b1;

  localparam logic [15:0] RESEND_PERIOD_RST = 16'd20;

  // controller -> datapath
  typedef struct packed {
    logic wr_byte;     // store byte at tail slot, bump load position
    logic set_drop;    // queue full: discard rest of message
    logic drop_emit;   // final byte of a discarded message
    logic commit;      // close message into tail slot
    logic tmr_inc;
    logic tmr_clear;
    logic tmr_start;   // count to 0, timer running
    logic tmr_stop;    // count to 0, timer stopped
    logic head_adv;    // pop head slot
    logic rd_en;       // read one byte of head message
    logic rd_last;
    logic rd_resend;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic q_empty;
    logic q_full;
    logic q_multi;     // more than one message queued
    logic dropping;
    logic pos_room;    // load position below message limit
    logic running;
    logic hit;         // next tick reaches the period
  } dp_status_t;

endpackage
`default_nettype wire

### design/scrq_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scrq_ctrl: resend queue controller
// Decodes each item and steps the byte replay of the head message.
// ----------------------------------------------------------------------------
module scrq_ctrl #(
  parameter int MAX_MESSAGE_BYTES = 64
) (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      start,
  input  wire [1:0]                in_op,
  input  wire                      in_last_byte,
  input  scrq_pkg::dp_status_t     status,
  input  wire [$clog2(MAX_MESSAGE_BYTES+1)-1:0] head_len,
  output logic                     busy,
  output scrq_pkg::dp_cmd_t        cmd,
  output logic [((MAX_MESSAGE_BYTES > 1) ? $clog2(MAX_MESSAGE_BYTES) : 1)-1:0] rd_idx
);
  import scrq_pkg::*;

  localparam int PW = $clog2(MAX_MESSAGE_BYTES + 1);
  localparam int BW = (MAX_MESSAGE_BYTES > 1) ? $clog2(MAX_MESSAGE_BYTES) : 1;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SEND = 2'b10
  } state_t;

  state_t        state_r, state_nxt;
  logic [BW-1:0] idx_r, idx_nxt;
  logic          resend_r, resend_nxt;
  logic          accept;
  logic          drop_now;
  logic          go_send;

  assign accept   = start && (state_r == ST_IDLE);
  assign drop_now = status.dropping || status.q_full;
  assign busy     = (state_r == ST_SEND);
  assign rd_idx   = idx_r;

  always_comb begin
    cmd        = '0;
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    resend_nxt = resend_r;
    go_send    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_op)
            OP_LOAD: begin
              cmd.set_drop = status.q_full;
              cmd.wr_byte  = !drop_now && status.pos_room;
              if (in_last_byte) begin
                if (drop_now) begin
                  cmd.drop_emit = 1'b1;
                end else begin
                  cmd.commit = 1'b1;
                  if (status.q_empty) begin
                    cmd.tmr_start = 1'b1;
                    go_send       = 1'b1;
                    resend_nxt    = 1'b0;
                  end
                end
              end
            end
            OP_TICK: begin
              if (status.running) begin
                if (status.hit) begin
                  cmd.tmr_clear = 1'b1;
                  if (!status.q_empty) begin
                    go_send    = 1'b1;
                    resend_nxt = 1'b1;
                  end
                end else begin
                  cmd.tmr_inc = 1'b1;
                end
              end
            end
            OP_ACK: begin
              cmd.head_adv = !status.q_empty;
              if (status.q_multi) begin
                cmd.tmr_start = 1'b1;
                go_send       = 1'b1;
                resend_nxt    = 1'b0;
              end else begin
                cmd.tmr_stop = 1'b1;
              end
            end
            default: ;
          endcase
          if (go_send) begin
            state_nxt = ST_SEND;
            idx_nxt   = '0;
          end
        end
      end
      ST_SEND: begin
        cmd.rd_en     = 1'b1;
        cmd.rd_resend = resend_r;
        cmd.rd_last   = ((PW'(idx_r) + PW'(1)) == head_len);
        if (cmd.rd_last) begin
          state_nxt = ST_IDLE;
        end else begin
          idx_nxt = idx_r + BW'(1);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      idx_r    <= '0;
      resend_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      idx_r    <= idx_nxt;
      resend_r <= resend_nxt;
    end
  end

`ifndef SYNTH
  a_send_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SEND && cmd.rd_last) |=> (state_r == ST_IDLE))
    else $error("replay did not end after last byte");

  a_ack_sends_next: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_op == OP_ACK && status.q_multi) |=> (state_r == ST_SEND && !resend_r))
    else $error("ack with queued follower did not start a send");
`endif

endmodule
`default_nettype wire

### design/scrq_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// scrq_datapath: resend queue storage, pointers, timer and result register
// Message bytes live in one RAM addressed by {slot, byte index}.
// ----------------------------------------------------------------------------
module scrq_datapath #(
  parameter int QUEUE_SLOTS       = 8,
  parameter int MAX_MESSAGE_BYTES = 64
) (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      cfg_we,
  input  wire [15:0]               cfg_wdata,
  input  wire [1:0]                in_port,
  input  wire [7:0]                in_data_byte,
  input  scrq_pkg::dp_cmd_t        cmd,
  input  wire [((MAX_MESSAGE_BYTES > 1) ? $clog2(MAX_MESSAGE_BYTES) : 1)-1:0] rd_idx,
  output scrq_pkg::dp_status_t     status,
  output logic [$clog2(MAX_MESSAGE_BYTES+1)-1:0] head_len,
  output logic                     out_strobe,
  output logic                     out_event_res,
  output logic [1:0]               out_tx_port,
  output logic [7:0]               out_tx_byte,
  output logic                     out_is_resend,
  output logic                     out_last_of_run
);
  import scrq_pkg::*;

  localparam int SW        = $clog2(QUEUE_SLOTS);
  localparam int CW        = $clog2(QUEUE_SLOTS + 1);
  localparam int PW        = $clog2(MAX_MESSAGE_BYTES + 1);
  localparam int BW        = (MAX_MESSAGE_BYTES > 1) ? $clog2(MAX_MESSAGE_BYTES) : 1;
  localparam int AW        = SW + BW;
  localparam int MEM_DEPTH = QUEUE_SLOTS * (2 ** BW);

  logic [15:0]   period_r;
  logic [SW-1:0] head_r, tail_r;
  logic [CW-1:0] count_r;
  logic [PW-1:0] pos_r;
  logic          dropping_r;
  logic [15:0]   tcount_r;
  logic          running_r;

  logic [PW-1:0] slot_len_r  [QUEUE_SLOTS];
  logic [1:0]    slot_port_r [QUEUE_SLOTS];
  logic [7:0]    mem [0:MEM_DEPTH-1];

  logic [7:0]    rd_data_r;
  logic          out_valid_r;
  logic          out_event_r;
  logic [1:0]    out_port_r;
  logic          out_resend_r;
  logic          out_last_r;

  logic [AW-1:0] waddr, raddr;

  assign waddr = {tail_r, pos_r[BW-1:0]};
  assign raddr = {head_r, rd_idx};

  assign status.q_empty  = (count_r == '0);
  assign status.q_full   = (count_r >= CW'(QUEUE_SLOTS));
  assign status.q_multi  = (count_r > CW'(1));
  assign status.dropping = dropping_r;
  assign status.pos_room = (pos_r < PW'(MAX_MESSAGE_BYTES));
  assign status.running  = running_r;
  assign status.hit      = (({1'b0, tcount_r} + 17'd1) >= {1'b0, period_r});

  assign head_len = slot_len_r[head_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r   <= RESEND_PERIOD_RST;
      head_r     <= '0;
      tail_r     <= '0;
      count_r    <= '0;
      pos_r      <= '0;
      dropping_r <= 1'b0;
      tcount_r   <= '0;
      running_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        period_r <= cfg_wdata;
      end
      if (cmd.commit || cmd.drop_emit) begin
        pos_r <= '0;
      end else if (cmd.wr_byte) begin
        pos_r <= pos_r + PW'(1);
      end
      if (cmd.drop_emit) begin
        dropping_r <= 1'b0;
      end else if (cmd.set_drop) begin
        dropping_r <= 1'b1;
      end
      if (cmd.commit) begin
        tail_r  <= (tail_r == SW'(QUEUE_SLOTS - 1)) ? '0 : tail_r + SW'(1);
        count_r <= count_r + CW'(1);
      end else if (cmd.head_adv) begin
        head_r  <= (head_r == SW'(QUEUE_SLOTS - 1)) ? '0 : head_r + SW'(1);
        count_r <= count_r - CW'(1);
      end
      if (cmd.tmr_start) begin
        tcount_r  <= '0;
        running_r <= 1'b1;
      end else if (cmd.tmr_stop) begin
        tcount_r  <= '0;
        running_r <= 1'b0;
      end else if (cmd.tmr_clear) begin
        tcount_r <= '0;
      end else if (cmd.tmr_inc) begin
        tcount_r <= tcount_r + 16'd1;
      end
    end
  end

  // slot descriptors: no reset, only read once written
  // final byte counts toward the length when it was stored this cycle
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      slot_len_r[tail_r]  <= cmd.wr_byte ? pos_r + PW'(1) : pos_r;
      slot_port_r[tail_r] <= in_port;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_byte) begin
      mem[waddr] <= in_data_byte;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[raddr];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.rd_en || cmd.drop_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      out_event_r  <= EV_TX;
      out_port_r   <= slot_port_r[head_r];
      out_resend_r <= cmd.rd_resend;
      out_last_r   <= cmd.rd_last;
    end else if (cmd.drop_emit) begin
      out_event_r  <= EV_DROP;
      out_port_r   <= in_port;
      out_resend_r <= 1'b0;
      out_last_r   <= 1'b1;
    end
  end

  assign out_strobe      = out_valid_r;
  assign out_event_res   = out_event_r;
  assign out_tx_port     = out_port_r;
  assign out_tx_byte     = (out_event_r == EV_DROP) ? 8'd0 : rd_data_r;
  assign out_is_resend   = out_resend_r;
  assign out_last_of_run = out_last_r;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(QUEUE_SLOTS))
    else $error("queue count above slot count");

  a_timer_needs_msg: assert property (@(posedge clk) disable iff (!rst_n)
    running_r |-> (count_r != '0))
    else $error("resend timer running with empty queue");
`endif

endmodule
`default_nettype wire

### design/serial_command_resend_queue_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// serial_command_resend_queue_unit: stop-and-wait resend queue
// Queues serial messages, transmits the head and replays it on timeout
// until acknowledged.
// ----------------------------------------------------------------------------
// Usage:
//  - Input: drive in_op/in_port/in_data_byte/in_last_byte with start high;
//    the item is taken at an edge where busy is low. Ops: load byte, timer
//    tick, acknowledge head.
//  - Output: each result item shows for one cycle with out_strobe high;
//    the receiver cannot stall, so nothing is held back.
//  - Config: cfg_we/cfg_wdata write resend_period; write only when idle.
//  - Latency: a transmitted byte is read in the replay state and then passes
//    the RAM read register before it shows; a drop notice shows in the
//    cycle right after the final byte is taken.
//  - Throughput: items that send nothing (byte loads, idle ticks, drops)
//    go at one per cycle while busy is low. An item that sends the head
//    message holds busy while the single read port of the message RAM
//    replays its bytes (1..MAX_MESSAGE_BYTES) one byte a cycle.
//  - Reset: rst_n (sync, active low) empties the queue, stops the timer and
//    loads the period with 20. Message RAM and slot descriptors are not
//    cleared; only slots that hold a complete message are ever read.
// ----------------------------------------------------------------------------
module serial_command_resend_queue_unit #(
  parameter int QUEUE_SLOTS       = 8,
  parameter int MAX_MESSAGE_BYTES = 64
) (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        cfg_we,
  input  wire [15:0] cfg_wdata,
  input  wire        start,
  output logic       busy,
  input  wire [1:0]  in_op,
  input  wire [1:0]  in_port,
  input  wire [7:0]  in_data_byte,
  input  wire        in_last_byte,
  output logic       out_strobe,
  output logic       out_event_res,
  output logic [1:0] out_tx_port,
  output logic [7:0] out_tx_byte,
  output logic       out_is_resend,
  output logic       out_last_of_run
);
  import scrq_pkg::*;

  localparam int PW = $clog2(MAX_MESSAGE_BYTES + 1);
  localparam int BW = (MAX_MESSAGE_BYTES > 1) ? $clog2(MAX_MESSAGE_BYTES) : 1;

  dp_cmd_t       cmd;      // controller commands for this cycle
  dp_status_t    status;   // queue / timer flags
  logic [PW-1:0] head_len; // byte count of head message
  logic [BW-1:0] rd_idx;   // replay byte index

  scrq_ctrl #(
    .MAX_MESSAGE_BYTES (MAX_MESSAGE_BYTES)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .in_op        (in_op),
    .in_last_byte (in_last_byte),
    .status       (status),
    .head_len     (head_len),
    .busy         (busy),
    .cmd          (cmd),
    .rd_idx       (rd_idx)
  );

  scrq_datapath #(
    .QUEUE_SLOTS       (QUEUE_SLOTS),
    .MAX_MESSAGE_BYTES (MAX_MESSAGE_BYTES)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_port         (in_port),
    .in_data_byte    (in_data_byte),
    .cmd             (cmd),
    .rd_idx          (rd_idx),
    .status          (status),
    .head_len        (head_len),
    .out_strobe      (out_strobe),
    .out_event_res   (out_event_res),
    .out_tx_port     (out_tx_port),
    .out_tx_byte     (out_tx_byte),
    .out_is_resend   (out_is_resend),
    .out_last_of_run (out_last_of_run)
  );

endmodule
`default_nettype wire

### verif/serial_command_resend_queue_unit_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// serial_command_resend_queue_unit_tb: self-checking bench for the resend queue
// Drives load/tick/ack items through the start/busy port and keeps a mirror
// of the queue, the message slots and the resend timer. Each accepted item
// updates the mirror, which queues the transmit or drop result items that the
// block must produce. Every strobed result is matched field by field against
// the oldest pending one. Directed cases come first, then three random phases
// with different sender gap rates and resend periods.
// ----------------------------------------------------------------------------
module serial_command_resend_queue_unit_tb;
  import scrq_pkg::*;

  localparam int         SLOTS         = 8;
  localparam int         MSG_BYTES     = 64;
  localparam logic [1:0] OP_UNUSED     = 2'd3;   // no meaning, block ignores it
  // Load items can still be in flight after the last result shows; this wait
  // lets them settle through the replay state and the result registers.
  localparam int         SETTLE_CYCLES = 8;
  // Worst case is roughly 300 items each replaying 64 bytes with long sender
  // gaps; this leaves a wide margin on top.
  localparam int         CYCLE_LIMIT   = 300000;

  // One transmitted byte or drop notice as seen on the out_ ports.
  typedef struct packed {
    logic       ev;
    logic [1:0] tx_port;
    logic [7:0] tx_byte;
    logic       resend;
    logic       run_last;
  } tx_item_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [15:0] cfg_wdata;
  logic        start;
  logic        busy;
  logic [1:0]  in_op;
  logic [1:0]  in_port;
  logic [7:0]  in_data_byte;
  logic        in_last_byte;
  logic        out_strobe;
  logic        out_event_res;
  logic [1:0]  out_tx_port;
  logic [7:0]  out_tx_byte;
  logic        out_is_resend;
  logic        out_last_of_run;

  serial_command_resend_queue_unit #(
    .QUEUE_SLOTS      (SLOTS),
    .MAX_MESSAGE_BYTES(MSG_BYTES)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .start          (start),
    .busy           (busy),
    .in_op          (in_op),
    .in_port        (in_port),
    .in_data_byte   (in_data_byte),
    .in_last_byte   (in_last_byte),
    .out_strobe     (out_strobe),
    .out_event_res  (out_event_res),
    .out_tx_port    (out_tx_port),
    .out_tx_byte    (out_tx_byte),
    .out_is_resend  (out_is_resend),
    .out_last_of_run(out_last_of_run)
  );

  // 10 time unit clock, low half first.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // --------------------------------------------------------------------------
  // Queue mirror: what the block should hold after each accepted item.
  // --------------------------------------------------------------------------
  logic [7:0]  mirror_store [SLOTS][MSG_BYTES];
  logic [6:0]  mirror_len   [SLOTS];
  logic [1:0]  mirror_port  [SLOTS];
  logic [2:0]  mirror_head;
  logic [2:0]  mirror_tail;        // 3 bits: wraps at SLOTS on its own
  int          mirror_count;
  int          mirror_load_pos;
  bit          mirror_dropping;
  logic [15:0] mirror_timer;
  bit          mirror_running;
  logic [15:0] mirror_period;

  tx_item_t    pending_tx [$];     // results owed by the block, oldest first

  int          mismatch_count;
  int          items_sent;         // counts items that mean something
  int          sender_idle_pct;
  int          cycle_count;

  // Push every byte of the head message, in order; last byte closes the run.
  task automatic mirror_replay_head(input logic resend);
    tx_item_t t;
    int       n;
    n = int'(mirror_len[mirror_head]);
    for (int i = 0; i < n; i++) begin
      t.ev       = EV_TX;
      t.tx_port  = mirror_port[mirror_head];
      t.tx_byte  = mirror_store[mirror_head][i];
      t.resend   = resend;
      t.run_last = (i == n - 1);
      pending_tx.push_back(t);
    end
  endtask

  // First transmission of a new head: restarts the timer.
  task automatic mirror_start_head();
    if (mirror_count != 0) begin
      mirror_timer   = 16'd0;
      mirror_running = 1'b1;
      mirror_replay_head(1'b0);
    end
  endtask

  task automatic apply_to_queue_mirror(input logic [1:0] op, input logic [1:0] prt,
                                       input logic [7:0] data, input logic is_last);
    tx_item_t t;
    bit       was_empty;
    case (op)
      OP_LOAD: begin
        // A full queue at any byte discards the rest of that message.
        if (mirror_count >= SLOTS) mirror_dropping = 1'b1;
        // Bytes past the slot size are silently lost (truncation).
        if (!mirror_dropping && mirror_load_pos < MSG_BYTES) begin
          mirror_store[mirror_tail][mirror_load_pos] = data;
          mirror_load_pos++;
        end
        if (is_last) begin
          if (mirror_dropping) begin
            mirror_dropping = 1'b0;
            mirror_load_pos = 0;
            t.ev       = EV_DROP;
            t.tx_port  = prt;
            t.tx_byte  = 8'd0;
            t.resend   = 1'b0;
            t.run_last = 1'b1;
            pending_tx.push_back(t);
          end else begin
            // Commit; port comes from the final byte only.
            was_empty                = (mirror_count == 0);
            mirror_len[mirror_tail]  = 7'(mirror_load_pos);
            mirror_port[mirror_tail] = prt;
            mirror_tail              = mirror_tail + 3'd1;
            mirror_count++;
            mirror_load_pos = 0;
            if (was_empty) mirror_start_head();
          end
        end
      end
      OP_TICK: begin
        // Stopped timer ignores ticks. Period 0 acts like 1 via the >= test.
        if (mirror_running) begin
          mirror_timer = mirror_timer + 16'd1;
          if (mirror_timer >= mirror_period) begin
            mirror_timer = 16'd0;
            if (mirror_count != 0) mirror_replay_head(1'b1);
          end
        end
      end
      OP_ACK: begin
        // Ack on an empty queue only stops the timer.
        mirror_running = 1'b0;
        mirror_timer   = 16'd0;
        if (mirror_count != 0) begin
          mirror_head = mirror_head + 3'd1;
          mirror_count--;
        end
        mirror_start_head();
      end
      default: ;
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Result checking
  // --------------------------------------------------------------------------
  task automatic flag_mismatch(input string what);
    mismatch_count++;
    $display("[%0d] mismatch: %s", cycle_count, what);
  endtask

  // Outputs are sampled at the rising edge, before the block updates them.
  always @(posedge clk) begin : check_results
    tx_item_t want;
    if (rst_n && out_strobe) begin
      if (pending_tx.size() == 0) begin
        flag_mismatch($sformatf("unexpected result ev=%0d port=%0d byte=%02h",
                                out_event_res, out_tx_port, out_tx_byte));
      end else begin
        want = pending_tx.pop_front();
        if (out_event_res !== want.ev)
          flag_mismatch($sformatf("event_res %0d, want %0d", out_event_res, want.ev));
        if (out_tx_port !== want.tx_port)
          flag_mismatch($sformatf("tx_port %0d, want %0d", out_tx_port, want.tx_port));
        if (out_tx_byte !== want.tx_byte)
          flag_mismatch($sformatf("tx_byte %02h, want %02h", out_tx_byte, want.tx_byte));
        if (out_is_resend !== want.resend)
          flag_mismatch($sformatf("is_resend %0d, want %0d", out_is_resend, want.resend));
        if (out_last_of_run !== want.run_last)
          flag_mismatch($sformatf("last_of_run %0d, want %0d", out_last_of_run,
                                  want.run_last));
      end
    end
  end

  // Watchdog on total run length.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_tx.size());
      $display("serial_command_resend_queue_unit regression: fail");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  // Drive one item at a falling edge, with random gaps ahead of it, and hold
  // it until an edge with busy low takes it. start is left high on return so
  // back-to-back items need no extra assignment; the caller's next negedge
  // either drives a new item or drops start.
  task automatic send_item(input logic [1:0] op, input logic [1:0] prt,
                           input logic [7:0] data, input logic is_last);
    @(negedge clk);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start        <= 1'b1;
    in_op        <= op;
    in_port      <= prt;
    in_data_byte <= data;
    in_last_byte <= is_last;
    do @(posedge clk); while (busy !== 1'b0);
    apply_to_queue_mirror(op, prt, data, is_last);
    if (op != OP_UNUSED) items_sent++;
  endtask

  // Drop start, let every owed result arrive, then let trailing loads settle.
  task automatic wait_until_idle();
    @(negedge clk);
    start <= 1'b0;
    while (pending_tx.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_period(input logic [15:0] value);
    wait_until_idle();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    mirror_period = value;
  endtask

  // Message of len bytes with random content and ports. break_pct slips a
  // tick or ack in between bytes now and then.
  task automatic send_random_message(input int len, input int break_pct);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 99) < break_pct)
        send_item($urandom_range(0, 1) ? OP_TICK : OP_ACK, 2'($urandom_range(0, 3)),
                  8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
      send_item(OP_LOAD, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                i == len - 1);
    end
  endtask

  // Mostly well-formed traffic: whole messages, ticks and acks, with an odd
  // unused op as noise. Messages are short except for a rare long one that may run past the slot size.
  task automatic run_random_traffic(input int n_items, input int idle_pct);
    int goal;
    int pick;
    int len;
    sender_idle_pct = idle_pct;
    goal = items_sent + n_items;
    while (items_sent < goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        len = ($urandom_range(0, 99) < 4) ? $urandom_range(60, 70) : $urandom_range(1, 6);
        send_random_message(len, 8);
      end else if (pick < 67) begin
        send_item(OP_TICK, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)));
      end else if (pick < 95) begin
        send_item(OP_ACK, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)));
      end else begin
        send_item(OP_UNUSED, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)));
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Nothing queued: ack, tick with the timer stopped and the unused op all
  // must stay silent.
  task automatic test_idle_ops();
    send_item(OP_ACK, 2'd1, 8'h00, 1'b0);
    send_item(OP_TICK, 2'd2, 8'hFF, 1'b1);
    send_item(OP_UNUSED, 2'd3, 8'hA5, 1'b1);
  endtask

  // One byte message goes out at once, resends after the period, ack clears.
  task automatic test_single_message();
    write_period(16'd2);
    send_item(OP_LOAD, 2'd3, 8'hFF, 1'b1);
    send_item(OP_TICK, 2'd0, 8'h00, 1'b0);
    send_item(OP_TICK, 2'd0, 8'h00, 1'b0);
    send_item(OP_ACK, 2'd0, 8'h00, 1'b0);
  endtask

  // Port changes mid message; the one on the final byte wins.
  task automatic test_port_from_last_byte();
    send_item(OP_LOAD, 2'd1, 8'h00, 1'b0);
    send_item(OP_LOAD, 2'd3, 8'h55, 1'b0);
    send_item(OP_LOAD, 2'd2, 8'hAA, 1'b1);
    send_item(OP_ACK, 2'd0, 8'h00, 1'b0);
  endtask

  // 66 bytes loaded: only the first 64 are sent.
  task automatic test_overlong_message();
    send_random_message(66, 0);
    send_item(OP_TICK, 2'd0, 8'h00, 1'b0);
    send_item(OP_TICK, 2'd0, 8'h00, 1'b0);
    send_item(OP_ACK, 2'd0, 8'h00, 1'b0);
  endtask

  // Period 0 resends on every tick; period 65535 never within a few ticks.
  task automatic test_period_extremes();
    write_period(16'h0000);
    send_item(OP_LOAD, 2'd0, 8'h3C, 1'b1);
    send_item(OP_TICK, 2'd0, 8'h00, 1'b0);
    send_item(OP_TICK, 2'd0, 8'h00, 1'b0);
    write_period(16'hFFFF);
    send_item(OP_TICK, 2'd0, 8'h00, 1'b0);
    send_item(OP_TICK, 2'd0, 8'h00, 1'b0);
    send_item(OP_ACK, 2'd0, 8'h00, 1'b0);
  endtask

  // Fill all slots, then a two byte message must come back as one drop notice
  // carrying the port of its final byte. The queue is left full on purpose.
  task automatic test_queue_full();
    write_period(16'd3);
    for (int i = 0; i < SLOTS; i++)
      send_item(OP_LOAD, 2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)), 1'b1);
    send_item(OP_LOAD, 2'd0, 8'h11, 1'b0);
    send_item(OP_LOAD, 2'd1, 8'h22, 1'b1);
  endtask

  task automatic test_random_light_gaps();
    write_period(16'($urandom_range(1, 4)));
    run_random_traffic(70, 18);
  endtask

  task automatic test_random_heavy_gaps();
    write_period(16'($urandom_range(2, 6)));
    run_random_traffic(70, 51);
  endtask

  task automatic test_random_back_to_back();
    write_period(16'd1);
    run_random_traffic(70, 0);
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_wdata       = 16'd0;
    start           = 1'b0;
    in_op           = OP_LOAD;
    in_port         = 2'd0;
    in_data_byte    = 8'd0;
    in_last_byte    = 1'b0;
    mismatch_count  = 0;
    items_sent      = 0;
    sender_idle_pct = 0;
    cycle_count     = 0;
    // Mirror reset state: empty queue, stopped timer, period at its default.
    mirror_head     = 3'd0;
    mirror_tail     = 3'd0;
    mirror_count    = 0;
    mirror_load_pos = 0;
    mirror_dropping = 1'b0;
    mirror_timer    = 16'd0;
    mirror_running  = 1'b0;
    mirror_period   = RESEND_PERIOD_RST;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_idle_ops();
    test_single_message();
    test_port_from_last_byte();
    test_overlong_message();
    test_period_extremes();
    test_queue_full();
    test_random_light_gaps();
    test_random_heavy_gaps();
    test_random_back_to_back();

    wait_until_idle();
    if (mismatch_count == 0) begin
      $display("serial_command_resend_queue_unit regression: pass");
    end else begin
      $display("serial_command_resend_queue_unit regression: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire
